// ----- rtl/mfwm_pkg.sv -----
// ----------------------------------------------------------------------------
// mfwm_pkg
// shared sizes, codes and types of the mutex manager with fifo wait queues
// ----------------------------------------------------------------------------
package mfwm_pkg;

  localparam int MUTEX_SLOTS = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int PID_BITS    = 16;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 4;
  localparam int PID_W    = 16;
  localparam int STATUS_W = 3;

  localparam int SLOT_W  = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
  localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int WAITERS = MUTEX_SLOTS * QUEUE_DEPTH;
  localparam int ADDR_W  = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int STORE_W = (PID_BITS < PID_W) ? PID_BITS : PID_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE  = 2'd0,
    FUNC_DESTROY = 2'd1,
    FUNC_LOCK    = 2'd2,
    FUNC_UNLOCK  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_HANDOFF   = 3'd3,
    ST_CREATED   = 3'd4,
    ST_DESTROYED = 3'd5,
    ST_QFULL     = 3'd6,
    ST_INVALID   = 3'd7
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [ID_W-1:0]   mutex_id;
    logic [PID_W-1:0]  pid;
  } op_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    rid;
    logic               handoff;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [STORE_W-1:0] mem_wdata;
  } dec_t;

endpackage

// ----- rtl/mfwm_req_if.sv -----
// ----------------------------------------------------------------------------
// mfwm_req_if
// request channel: operation, mutex slot and caller pid
// ----------------------------------------------------------------------------
interface mfwm_req_if;
  import mfwm_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   mutex_id;
  logic [PID_W-1:0]  pid;

  modport source (output valid, output func, output mutex_id, output pid, input ready);
  modport sink   (input valid, input func, input mutex_id, input pid, output ready);
endinterface

// ----- rtl/mfwm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mfwm_rsp_if
// response channel: status, slot index and woken pid
// ----------------------------------------------------------------------------
interface mfwm_rsp_if;
  import mfwm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     result_id;
  logic [PID_W-1:0]    woken_pid;

  modport source (output valid, output status, output result_id, output woken_pid,
                  input ready);
  modport sink   (input valid, input status, input result_id, input woken_pid,
                  output ready);
endinterface

// ----- rtl/mfwm_slot_table.sv -----
// ----------------------------------------------------------------------------
// mfwm_slot_table
// per-slot valid, lock, queue head and count, and the decision for one op
// ----------------------------------------------------------------------------
module mfwm_slot_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  mfwm_pkg::op_t op,
  output mfwm_pkg::dec_t dec
);
  import mfwm_pkg::*;

  logic [MUTEX_SLOTS-1:0] valid;
  logic [MUTEX_SLOTS-1:0] locked;
  logic [HEAD_W-1:0]      head  [MUTEX_SLOTS];
  logic [CNT_W-1:0]       count [MUTEX_SLOTS];

  logic              in_range;
  logic [SLOT_W-1:0] sel;
  logic              ok;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [HEAD_W-1:0] cur_head;
  logic [CNT_W-1:0]  cur_count;
  logic [CNT_W:0]    tail_sum;
  logic [HEAD_W-1:0] tail;
  logic [HEAD_W-1:0] head_inc;

  logic              upd_en;
  logic [SLOT_W-1:0] upd_slot;
  logic              upd_valid;
  logic              upd_locked;
  logic [HEAD_W-1:0] upd_head;
  logic [CNT_W-1:0]  upd_count;

  always_comb begin
    in_range = (int'(op.mutex_id) < MUTEX_SLOTS);
    sel      = in_range ? SLOT_W'(op.mutex_id) : '0;
    ok       = in_range && valid[sel];
    cur_head  = head[sel];
    cur_count = count[sel];
    tail_sum  = (CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_count);
    tail      = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                HEAD_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
    head_inc  = (cur_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MUTEX_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    dec.status    = ST_INVALID;
    dec.rid       = op.mutex_id;
    dec.handoff   = 1'b0;
    dec.mem_we    = 1'b0;
    dec.mem_re    = 1'b0;
    dec.mem_addr  = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_head);
    dec.mem_wdata = STORE_W'(op.pid);
    upd_en     = 1'b0;
    upd_slot   = sel;
    upd_valid  = valid[sel];
    upd_locked = locked[sel];
    upd_head   = cur_head;
    upd_count  = cur_count;
    if (op.func == FUNC_CREATE) begin
      dec.rid = '0;
      if (free_found) begin
        dec.rid    = ID_W'(free_idx);
        dec.status = ST_CREATED;
        upd_en     = 1'b1;
        upd_slot   = free_idx;
        upd_valid  = 1'b1;
        upd_locked = 1'b0;
        upd_head   = '0;
        upd_count  = '0;
      end
    end else if (ok) begin
      unique case (op.func)
        FUNC_DESTROY: begin
          dec.status = ST_DESTROYED;
          upd_en     = 1'b1;
          upd_valid  = 1'b0;
          upd_locked = 1'b0;
          upd_head   = '0;
          upd_count  = '0;
        end
        FUNC_LOCK: begin
          if (!locked[sel]) begin
            dec.status = ST_GRANTED;
            upd_en     = 1'b1;
            upd_locked = 1'b1;
          end else if (cur_count >= CNT_W'(QUEUE_DEPTH)) begin
            dec.status = ST_QFULL;
          end else begin
            dec.status   = ST_QUEUED;
            dec.mem_we   = 1'b1;
            dec.mem_addr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail);
            upd_en       = 1'b1;
            upd_count    = cur_count + 1'b1;
          end
        end
        FUNC_UNLOCK: begin
          upd_en = 1'b1;
          if (cur_count != '0) begin
            dec.status  = ST_HANDOFF;
            dec.handoff = 1'b1;
            dec.mem_re  = 1'b1;
            upd_locked  = 1'b1;
            upd_head    = head_inc;
            upd_count   = cur_count - 1'b1;
          end else begin
            dec.status = ST_RELEASED;
            upd_locked = 1'b0;
          end
        end
        default: begin
          dec.status = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      locked <= '0;
      for (int i = 0; i < MUTEX_SLOTS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else if (fire && upd_en) begin
      valid[upd_slot]  <= upd_valid;
      locked[upd_slot] <= upd_locked;
      head[upd_slot]   <= upd_head;
      count[upd_slot]  <= upd_count;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> (valid == '0 && locked == '0))
    else $error("slot table not cleared by reset");
  a_waiters_imply_lock: assert property (@(posedge clk) disable iff (rst)
    (fire && ok && cur_count != '0) |-> locked[sel])
    else $error("waiters queued on an unlocked mutex");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fire |-> (cur_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");
  a_create_marks_valid: assert property (@(posedge clk) disable iff (rst)
    (fire && dec.status == ST_CREATED) |=> valid[$past(free_idx)])
    else $error("created slot not marked valid");
`endif

endmodule

// ----- rtl/mfwm_waiter_store.sv -----
// ----------------------------------------------------------------------------
// mfwm_waiter_store
// single-port memory of queued pids with registered read data
// ----------------------------------------------------------------------------
module mfwm_waiter_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [mfwm_pkg::ADDR_W-1:0]  addr,
  input  logic [mfwm_pkg::STORE_W-1:0] wdata,
  output logic [mfwm_pkg::STORE_W-1:0] rdata
);
  import mfwm_pkg::*;

  logic [STORE_W-1:0] mem [WAITERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/mutex_fifo_wait_manager.sv -----
// ----------------------------------------------------------------------------
// mutex_fifo_wait_manager
// lock manager for a table of mutex slots, each with a fifo of waiting pids
// ----------------------------------------------------------------------------
// req carries one transaction per operation (func, mutex_id, pid); rsp returns
// exactly one transaction per request, in order (status, result_id,
// woken_pid). create takes the lowest free slot, destroy frees it, lock grants
// or queues the pid, unlock hands the lock to the oldest waiter or clears it.
// an accepted request is held in the input register, and its result is registered
// in the output register, from which rsp is driven.
// throughput: one request per cycle while the receiver takes rsp; the slot state is
// read and written in the same cycle and the waiter memory port serves one read or
// one write per request.
// reset clears every slot to free, unlocked and with an empty queue; the
// waiter memory is not cleared, only entries written by lock are read back.
// when the receiver stalls, the result stays in the output register, one more
// request is held in the input register, and then req.ready drops until rsp
// is taken.
// ----------------------------------------------------------------------------
module mutex_fifo_wait_manager (
  input logic        clk,
  input logic        rst,
  mfwm_req_if.sink   req,
  mfwm_rsp_if.source rsp
);
  import mfwm_pkg::*;

  logic               s1_valid;
  op_t                s1_op;
  logic               s1_adv;
  dec_t               dec;
  logic               out_valid;
  status_t            out_status;
  logic [ID_W-1:0]    out_rid;
  logic               out_handoff;
  logic [STORE_W-1:0] rdata;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op.func     <= func_t'(req.func);
      s1_op.mutex_id <= req.mutex_id;
      s1_op.pid      <= req.pid;
    end
  end

  mfwm_slot_table u_slot_table (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_adv),
    .op   (s1_op),
    .dec  (dec)
  );

  mfwm_waiter_store u_waiter_store (
    .clk   (clk),
    .we    (s1_adv && dec.mem_we),
    .re    (s1_adv && dec.mem_re),
    .addr  (dec.mem_addr),
    .wdata (dec.mem_wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status  <= dec.status;
      out_rid     <= dec.rid;
      out_handoff <= dec.handoff;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.result_id = out_rid;
  assign rsp.woken_pid = out_handoff ? PID_W'(rdata) : '0;

`ifndef SYNTHESIS
  a_held_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_op)))
    else $error("input register lost a stalled transaction");
  a_woken_only_on_handoff: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rsp.woken_pid != '0) |-> (out_status == ST_HANDOFF))
    else $error("woken pid on a non hand-off result");
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !rsp.ready) |-> !req.ready)
    else $error("request accepted with both stages full");
`endif

endmodule
